// File: rtl/tdp_pkg.sv
package tdp_pkg;

  // Width at which the input number is read; bit WIDTH-1 is the sign.
  localparam int unsigned WIDTH = 32;
  // Magnitude bits of a non-negative value.
  localparam int unsigned VAL_W = WIDTH - 1;
  localparam int unsigned CNT_W = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] FIRST_DIV = VAL_W'(5);
  localparam logic [VAL_W-1:0] DIV_STEP  = VAL_W'(6);
  localparam logic [VAL_W-1:0] DIV_PAIR  = VAL_W'(2);
  localparam logic [VAL_W-1:0] DIV_THREE = VAL_W'(3);

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
    logic [VAL_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/tdp_if.sv
interface tdp_num_if;
  logic                             valid;
  logic                             ready;
  logic signed [tdp_pkg::WIDTH-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface tdp_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

// File: rtl/trial_division_prime_test_unit.sv
// Primality test by 6k+/-1 trial division. One item in (number, read as
// signed two's complement), one item out (is_prime). Negative values, 0
// and 1 give 0; 2 and 3 give 1; even values decide at once. Otherwise a
// shared radix-2 restoring divider (one shift step per quotient bit, then
// a hand-over of the result) first divides by 3, then by d and d+2 for
// d = 5, 11, ...
// The division by d also yields the loop bound (stop when quotient < d),
// so the square never has to be formed. An item therefore takes one
// division by 3 and up to two divisions per loop pass, with up to about
// sqrt(n)/6 passes; trivially decided values need no division. The input
// is ready only while the sequencer is idle; the result sits in an output
// register, so the next item is taken while an earlier result still waits
// to be read.
module trial_division_prime_test_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdp_num_if.sink   in_i,
  tdp_res_if.source out_o
);
  import tdp_pkg::*;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic     res_valid;
  logic     res_ready;
  logic     res_prime;
  logic     out_valid_q;
  logic     out_prime_q;

  tdp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .number_i    (in_i.number),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_prime_o (res_prime),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  tdp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Output register: the sequencer hands over when the slot is free or
  // being emptied this cycle.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_prime_q <= res_prime;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.is_prime = out_prime_q;

endmodule

// File: rtl/tdp_div.sv
module tdp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdp_pkg::div_req_t req_i,
  output tdp_pkg::div_rsp_t rsp_o
);
  import tdp_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [VAL_W-1:0] dsr_q, dsr_d;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;

  // One restoring step per cycle, quotient bits shift in from the bottom.
  assign trial = {rem_q, quo_q[VAL_W-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      if (!diff[VAL_W]) begin
        rem_d = diff[VAL_W-1:0];
        quo_d = {quo_q[VAL_W-2:0], 1'b1};
      end else begin
        rem_d = trial[VAL_W-1:0];
        quo_d = {quo_q[VAL_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(VAL_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/tdp_ctrl.sv
module tdp_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tdp_pkg::WIDTH-1:0]   number_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        res_prime_o,
  output tdp_pkg::div_req_t           div_req_o,
  input  tdp_pkg::div_rsp_t           div_rsp_i
);
  import tdp_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV3 = 5'b00010,
    ST_DIVD = 5'b00100,
    ST_DIV2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] dv_q, dv_d;
  logic             prime_q, prime_d;
  logic [VAL_W-1:0] in_val;
  logic             in_neg;

  assign in_neg = number_i[WIDTH-1];
  assign in_val = number_i[VAL_W-1:0];

  always_comb begin
    state_d            = state_q;
    val_d              = val_q;
    dv_d               = dv_q;
    prime_d            = prime_q;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = val_q;
    div_req_o.divisor  = dv_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d = in_val;
          if (in_neg || in_val <= VAL_W'(1)) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else if (in_val <= DIV_THREE) begin
            prime_d = 1'b1;
            state_d = ST_DONE;
          end else if (!in_val[0]) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            div_req_o.start    = 1'b1;
            div_req_o.dividend = in_val;
            div_req_o.divisor  = DIV_THREE;
            state_d            = ST_DIV3;
          end
        end
      end
      ST_DIV3: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.remainder == '0) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            dv_d              = FIRST_DIV;
            div_req_o.start   = 1'b1;
            div_req_o.divisor = FIRST_DIV;
            state_d           = ST_DIVD;
          end
        end
      end
      ST_DIVD: begin
        // quotient < d means d*d > value: no factor left to find
        if (div_rsp_i.done) begin
          if (div_rsp_i.quotient < dv_q) begin
            prime_d = 1'b1;
            state_d = ST_DONE;
          end else if (div_rsp_i.remainder == '0) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            div_req_o.start   = 1'b1;
            div_req_o.divisor = dv_q + DIV_PAIR;
            state_d           = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.remainder == '0) begin
            prime_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            dv_d              = dv_q + DIV_STEP;
            div_req_o.start   = 1'b1;
            div_req_o.divisor = dv_q + DIV_STEP;
            state_d           = ST_DIVD;
          end
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    dv_q    <= dv_d;
    prime_q <= prime_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_prime_o = prime_q;

endmodule
